// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define LFSL_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define LFSL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/lfsl_pkg.sv =====
package lfsl_pkg;

    localparam int SENSOR_BITS_DEF = 16;
    localparam int FIELD_BITS      = 16;
    localparam int NORM_SHIFT      = 16;
    localparam int GAIN_BITS       = 10;
    localparam int SPEED_BITS      = 9;
    localparam int PWM_BITS        = 8;
    localparam int CFG_ADDR_BITS   = 4;
    localparam int CFG_DATA_BITS   = 32;

    localparam int INNER_DIV   = 24000;
    localparam int OUTER_L_DIV = 20690;
    localparam int NORM_CAP    = 65536;

    // raw thresholds: 0.8, 0.9, 0.7 of INNER_DIV (of OUTER_L_DIV for the _LO values)
    localparam logic [16:0] TH_08    = 17'd19200;
    localparam logic [16:0] TH_08_LO = 17'd16552;
    localparam logic [16:0] TH_09    = 17'd21600;
    localparam logic [16:0] TH_09_LO = 17'd18621;
    localparam logic [16:0] TH_07    = 17'd16800;
    localparam logic [16:0] TH_07_LO = 17'd14483;

    localparam logic [SPEED_BITS-1:0] SLOW_RST  = 9'd84;
    localparam logic [SPEED_BITS-1:0] FULL_RST  = 9'd256;
    localparam logic [GAIN_BITS-1:0]  INNER_RST = 10'd435;
    localparam logic [GAIN_BITS-1:0]  OUTER_RST = 10'd563;

    typedef enum logic [1:0] {
        REG_SLOW,
        REG_FULL,
        REG_INNER,
        REG_OUTER
    } t_reg_idx;

    typedef enum logic [1:0] {
        PH_READY,
        PH_POSITION,
        PH_WAIT,
        PH_DRIVE
    } t_phase;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_CALC,
        ST_HOLD
    } t_state;

    typedef struct packed {
        logic [FIELD_BITS-1:0] left_inner;
        logic [FIELD_BITS-1:0] right_inner;
        logic [FIELD_BITS-1:0] left_outer;
        logic [FIELD_BITS-1:0] right_outer;
        logic                  ir_level;
        logic                  button_level;
    } t_in_item;

    typedef struct packed {
        logic [PWM_BITS-1:0] left_pwm;
        logic [PWM_BITS-1:0] right_pwm;
        logic                left_reverse;
        logic                right_reverse;
        logic [1:0]          phase;
    } t_out_item;

    typedef struct packed {
        logic all08;
        logic all09;
        logic lo_low;
        logic ro_low;
        logic ir_level;
        logic button_level;
    } t_step_info;

    typedef struct packed {
        logic [GAIN_BITS-1:0] inner;
        logic [GAIN_BITS-1:0] outer;
    } t_gains;

    typedef struct packed {
        logic [PWM_BITS-1:0] left_pwm;
        logic [PWM_BITS-1:0] right_pwm;
        logic                left_reverse;
        logic                right_reverse;
    } t_drive;

endpackage

// ===== hdl/lfsl_div.sv =====
module lfsl_div #(
    parameter int SENSOR_BITS = lfsl_pkg::SENSOR_BITS_DEF,
    parameter int DIVISOR     = lfsl_pkg::INNER_DIV
) (
    input  logic                   i_clk,
    input  logic                   i_load,
    input  logic                   i_shift,
    input  logic [SENSOR_BITS-1:0] i_raw,
    output logic [SENSOR_BITS+1:0] o_quot
);
    import lfsl_pkg::*;

    localparam int NW = SENSOR_BITS + NORM_SHIFT;
    localparam int RW = $clog2(DIVISOR);
    localparam int QW = SENSOR_BITS + 2;
    localparam logic [RW:0] DIV_C = (RW+1)'(DIVISOR);

    logic [NW-1:0] r_num;
    logic [RW-1:0] r_rem;
    logic [QW-1:0] r_quot;
    logic [RW:0]   trial;
    logic [RW:0]   diff;
    logic          take;

    // restoring division, one quotient bit per cycle while i_shift is high
    always_comb begin
        trial = {r_rem, r_num[NW-1]};
        diff  = trial - DIV_C;
        take  = trial >= DIV_C;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_num  <= {i_raw, {NORM_SHIFT{1'b0}}};
            r_rem  <= '0;
            r_quot <= '0;
        end else if (i_shift) begin
            r_num  <= {r_num[NW-2:0], 1'b0};
            r_rem  <= take ? diff[RW-1:0] : trial[RW-1:0];
            r_quot <= {r_quot[QW-2:0], take};
        end
    end

    assign o_quot = r_quot;

endmodule

// ===== hdl/lfsl_steer.sv =====
module lfsl_steer #(
    parameter int SENSOR_BITS = lfsl_pkg::SENSOR_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [SENSOR_BITS+1:0]              i_q_li,
    input  logic [SENSOR_BITS+1:0]              i_q_ri,
    input  logic [SENSOR_BITS+1:0]              i_q_lo,
    input  logic [SENSOR_BITS+1:0]              i_q_ro,
    input  lfsl_pkg::t_gains                    i_gains,
    input  logic [lfsl_pkg::SPEED_BITS-1:0]     i_mult,
    output logic                                o_done,
    output lfsl_pkg::t_drive                    o_drive
);
    import lfsl_pkg::*;

    localparam int QW  = SENSOR_BITS + 2;
    localparam int DW  = QW + 1;
    localparam int PW  = DW + GAIN_BITS + 1;
    localparam int SW  = PW + 1;
    localparam int XW  = SW + 8;
    localparam int DRW = XW - 24;
    localparam int CMW = DRW + 10;
    localparam int MW  = PWM_BITS + SPEED_BITS;
    localparam logic [31:0] CAP = 32'(NORM_CAP);
    localparam logic signed [CMW-1:0] C256  = CMW'(256);
    localparam logic signed [CMW-1:0] C255  = CMW'(255);
    localparam logic signed [CMW-1:0] CN255 = -CMW'(255);

    // {negative, magnitude} of a command clamped to +-255
    function automatic logic [PWM_BITS:0] clamp_cmd(input logic signed [CMW-1:0] cmd);
        logic signed [CMW-1:0] neg_cmd;
        logic [PWM_BITS:0]     res;
        neg_cmd = -cmd;
        if (cmd > C255) begin
            res = {1'b0, 8'hFF};
        end else if (cmd < CN255) begin
            res = {1'b1, 8'hFF};
        end else if (cmd < 0) begin
            res = {1'b1, neg_cmd[PWM_BITS-1:0]};
        end else begin
            res = {1'b0, cmd[PWM_BITS-1:0]};
        end
        return res;
    endfunction

    logic [5:0]                 r_vld;
    logic [QW-1:0]              lo_cap;
    logic signed [DW-1:0]       diff_i;
    logic signed [DW-1:0]       diff_o;
    logic signed [GAIN_BITS:0]  gain_i;
    logic signed [GAIN_BITS:0]  gain_o;
    logic signed [PW-1:0]       r_pi;
    logic signed [PW-1:0]       r_po;
    logic signed [SW-1:0]       r_d;
    logic signed [XW-1:0]       d255;
    logic signed [DRW-1:0]      r_dir;
    logic signed [CMW-1:0]      cmd_l;
    logic signed [CMW-1:0]      cmd_r;
    logic [PWM_BITS:0]          cl_l;
    logic [PWM_BITS:0]          cl_r;
    logic [PWM_BITS-1:0]        r_lmag;
    logic [PWM_BITS-1:0]        r_rmag;
    logic                       r_lneg;
    logic                       r_rneg;
    logic                       r_lneg2;
    logic                       r_rneg2;
    logic [MW-1:0]              r_lm;
    logic [MW-1:0]              r_rm;
    logic [SPEED_BITS-1:0]      m_l;
    logic [SPEED_BITS-1:0]      m_r;

    always_comb begin
        lo_cap = ({{(32-QW){1'b0}}, i_q_lo} > CAP) ? CAP[QW-1:0] : i_q_lo;
        diff_i = $signed({1'b0, i_q_li}) - $signed({1'b0, i_q_ri});
        diff_o = $signed({1'b0, lo_cap}) - $signed({1'b0, i_q_ro});
        gain_i = $signed({1'b0, i_gains.inner});
        gain_o = $signed({1'b0, i_gains.outer});
        d255   = (XW'(r_d) <<< 8) - XW'(r_d);
        cmd_l  = C256 - CMW'(r_dir);
        cmd_r  = C255 + CMW'(r_dir);
        cl_l   = clamp_cmd(cmd_l);
        cl_r   = clamp_cmd(cmd_r);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[4:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        r_pi    <= diff_i * gain_i;
        r_po    <= diff_o * gain_o;
        r_d     <= SW'(r_pi) + SW'(r_po);
        r_dir   <= d255[XW-1:24];
        r_lmag  <= cl_l[PWM_BITS-1:0];
        r_lneg  <= cl_l[PWM_BITS];
        r_rmag  <= cl_r[PWM_BITS-1:0];
        r_rneg  <= cl_r[PWM_BITS];
        r_lm    <= MW'(r_lmag) * MW'(i_mult);
        r_rm    <= MW'(r_rmag) * MW'(i_mult);
        r_lneg2 <= r_lneg;
        r_rneg2 <= r_rneg;
    end

    always_comb begin
        m_l = r_lm[MW-1:8];
        m_r = r_rm[MW-1:8];
        o_drive.left_pwm      = (m_l > 9'd255) ? 8'hFF : m_l[PWM_BITS-1:0];
        o_drive.right_pwm     = (m_r > 9'd255) ? 8'hFF : m_r[PWM_BITS-1:0];
        o_drive.left_reverse  = r_lneg2 && (m_l != '0);
        o_drive.right_reverse = r_rneg2 && (m_r != '0);
    end

    assign o_done = r_vld[5];

endmodule

// ===== hdl/lfsl_ctrl.sv =====
`include "assert_macros.svh"

module lfsl_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  lfsl_pkg::t_step_info i_info,
    output lfsl_pkg::t_phase     o_phase_next,
    output logic                 o_moving,
    output logic                 o_slow
);
    import lfsl_pkg::*;

    t_phase     r_phase, n_phase;
    logic [1:0] r_lines, n_lines;
    logic [1:0] r_target, n_target;
    logic       r_on_line, n_on_line;
    logic       r_slow, n_slow;
    logic       r_btn_rel, n_btn_rel;

    // next state
    always_comb begin
        logic [1:0] lines_inc;
        n_phase   = r_phase;
        n_lines   = r_lines;
        n_target  = r_target;
        n_on_line = r_on_line;
        n_slow    = r_slow;
        n_btn_rel = r_btn_rel;
        lines_inc = r_lines + 2'd1;

        if (r_phase == PH_POSITION || r_phase == PH_DRIVE) begin
            if (i_info.all08) begin
                n_on_line = 1'b1;
                if (r_phase == PH_DRIVE && r_lines == 2'(r_target - 2'd1)) begin
                    n_phase = PH_READY;
                end
            end else if (r_on_line && i_info.lo_low && i_info.ro_low) begin
                n_lines   = lines_inc;
                n_on_line = 1'b0;
                if (lines_inc == r_target) begin
                    n_phase = (r_phase == PH_POSITION) ? PH_WAIT : PH_READY;
                end
            end
        end else if (r_phase == PH_WAIT && !i_info.ir_level) begin
            n_phase  = PH_DRIVE;
            n_lines  = 2'd0;
            n_slow   = 1'b0;
            n_target = 2'd2;
        end

        // button press edge acts on the phase left by the line logic
        if (!i_info.button_level) begin
            if (r_btn_rel) begin
                n_btn_rel = 1'b0;
                unique case (n_phase)
                    PH_READY: begin
                        if (!i_info.all09) begin
                            n_phase   = PH_POSITION;
                            n_on_line = 1'b0;
                            n_slow    = 1'b1;
                            n_target  = 2'd1;
                            n_lines   = 2'd0;
                        end
                    end
                    PH_WAIT: begin
                        n_phase  = PH_DRIVE;
                        n_lines  = 2'd0;
                        n_slow   = 1'b0;
                        n_target = 2'd2;
                    end
                    PH_POSITION, PH_DRIVE: begin
                        n_phase = PH_READY;
                    end
                    default: begin
                        n_phase = PH_READY;
                    end
                endcase
            end
        end else begin
            n_btn_rel = 1'b1;
        end
    end

    // outputs
    always_comb begin
        o_phase_next = n_phase;
        o_moving     = (r_phase == PH_POSITION) || (r_phase == PH_DRIVE);
        o_slow       = r_slow;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_READY;
            r_lines   <= 2'd0;
            r_target  <= 2'd0;
            r_on_line <= 1'b0;
            r_slow    <= 1'b0;
            r_btn_rel <= 1'b1;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_lines   <= n_lines;
            r_target  <= n_target;
            r_on_line <= n_on_line;
            r_slow    <= n_slow;
            r_btn_rel <= n_btn_rel;
        end
    end

    `LFSL_ASSERT_IMPL(a_target_set, r_phase == PH_POSITION || r_phase == PH_DRIVE, r_target != 2'd0, "moving with no line target")
    `LFSL_ASSERT_IMPL(a_drive_entry, r_phase == PH_DRIVE && $past(r_phase) != PH_DRIVE, r_lines == 2'd0, "driving entered with stale line count")

endmodule

// ===== hdl/line_follow_steer_and_lap_control_core.sv =====
// Each input transaction passes through the bit-serial normalizing dividers and then
// the steering pipeline. The next transaction is taken only once the result of the
// last one is stored in the output register.
// A stalled result is held in the output register while the next item is taken.
// Reset (synchronous, active low) clears phase and lap state and loads register defaults.
`include "assert_macros.svh"

module line_follow_steer_and_lap_control_core #(
    parameter int SENSOR_BITS = lfsl_pkg::SENSOR_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  lfsl_pkg::t_in_item                   i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output lfsl_pkg::t_out_item                  o_out_data,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [lfsl_pkg::CFG_ADDR_BITS-1:0]   paddr,
    input  logic [lfsl_pkg::CFG_DATA_BITS-1:0]   pwdata,
    output logic [lfsl_pkg::CFG_DATA_BITS-1:0]   prdata,
    output logic                                 pready
);
    import lfsl_pkg::*;

    localparam int NITER = SENSOR_BITS + NORM_SHIFT;
    localparam int CNTW  = $clog2(NITER);

    t_state                  r_state, n_state;
    logic [CNTW-1:0]         r_cnt;
    t_step_info              r_info, in_info;
    t_out_item               r_out, n_out;
    logic                    r_out_valid;
    logic [SPEED_BITS-1:0]   r_slow_speed;
    logic [SPEED_BITS-1:0]   r_full_speed;
    t_gains                  r_gains;

    logic                    div_load;
    logic                    div_shift;
    logic                    div_last;
    logic                    steer_start;
    logic                    steer_done;
    logic                    step;
    logic                    out_free;
    logic                    cfg_wr;
    logic [16:0]             li, ri, lo, ro;
    logic [SENSOR_BITS+1:0]  q_li, q_ri, q_lo, q_ro;
    t_drive                  drive;
    t_phase                  phase_next;
    logic                    moving;
    logic                    slow;

    // configuration
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slow_speed  <= SLOW_RST;
            r_full_speed  <= FULL_RST;
            r_gains.inner <= INNER_RST;
            r_gains.outer <= OUTER_RST;
        end else if (cfg_wr) begin
            unique case (t_reg_idx'(paddr[3:2]))
                REG_SLOW:  r_slow_speed  <= pwdata[SPEED_BITS-1:0];
                REG_FULL:  r_full_speed  <= pwdata[SPEED_BITS-1:0];
                REG_INNER: r_gains.inner <= pwdata[GAIN_BITS-1:0];
                REG_OUTER: r_gains.outer <= pwdata[GAIN_BITS-1:0];
                default:   r_slow_speed  <= r_slow_speed;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[3:2]))
            REG_SLOW:  prdata = CFG_DATA_BITS'(r_slow_speed);
            REG_FULL:  prdata = CFG_DATA_BITS'(r_full_speed);
            REG_INNER: prdata = CFG_DATA_BITS'(r_gains.inner);
            REG_OUTER: prdata = CFG_DATA_BITS'(r_gains.outer);
            default:   prdata = '0;
        endcase
    end

    // threshold flags on the raw readings
    always_comb begin
        li = 17'(i_in_data.left_inner[SENSOR_BITS-1:0]);
        ri = 17'(i_in_data.right_inner[SENSOR_BITS-1:0]);
        lo = 17'(i_in_data.left_outer[SENSOR_BITS-1:0]);
        ro = 17'(i_in_data.right_outer[SENSOR_BITS-1:0]);
        in_info.all08        = li > TH_08 && ri > TH_08 && lo > TH_08_LO && ro > TH_08;
        in_info.all09        = li > TH_09 && ri > TH_09 && lo > TH_09_LO && ro > TH_09;
        in_info.lo_low       = lo < TH_07_LO;
        in_info.ro_low       = ro < TH_07;
        in_info.ir_level     = i_in_data.ir_level;
        in_info.button_level = i_in_data.button_level;
    end

    // sequencer
    assign out_free = !r_out_valid || i_out_ready;
    assign div_last = r_cnt == CNTW'(NITER - 1);

    always_comb begin
        unique case (r_state)
            ST_IDLE: n_state = i_in_valid ? ST_DIV : ST_IDLE;
            ST_DIV:  n_state = div_last ? ST_CALC : ST_DIV;
            ST_CALC: begin
                if (steer_done) begin
                    n_state = out_free ? ST_IDLE : ST_HOLD;
                end else begin
                    n_state = ST_CALC;
                end
            end
            ST_HOLD: n_state = out_free ? ST_IDLE : ST_HOLD;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = r_state == ST_IDLE;
        div_load    = i_in_valid && (r_state == ST_IDLE);
        div_shift   = r_state == ST_DIV;
        steer_start = (r_state == ST_DIV) && div_last;
        step        = (((r_state == ST_CALC) && steer_done) || (r_state == ST_HOLD)) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (div_load) begin
                r_cnt <= '0;
            end else if (div_shift) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_out.left_pwm      = moving ? drive.left_pwm : '0;
        n_out.right_pwm     = moving ? drive.right_pwm : '0;
        n_out.left_reverse  = moving && drive.left_reverse;
        n_out.right_reverse = moving && drive.right_reverse;
        n_out.phase         = phase_next;
    end

    always_ff @(posedge i_clk) begin
        if (div_load) begin
            r_info <= in_info;
        end
        if (step) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    lfsl_div #(.SENSOR_BITS(SENSOR_BITS), .DIVISOR(INNER_DIV)) u_div_li (
        .i_clk   (i_clk),
        .i_load  (div_load),
        .i_shift (div_shift),
        .i_raw   (i_in_data.left_inner[SENSOR_BITS-1:0]),
        .o_quot  (q_li)
    );

    lfsl_div #(.SENSOR_BITS(SENSOR_BITS), .DIVISOR(INNER_DIV)) u_div_ri (
        .i_clk   (i_clk),
        .i_load  (div_load),
        .i_shift (div_shift),
        .i_raw   (i_in_data.right_inner[SENSOR_BITS-1:0]),
        .o_quot  (q_ri)
    );

    lfsl_div #(.SENSOR_BITS(SENSOR_BITS), .DIVISOR(OUTER_L_DIV)) u_div_lo (
        .i_clk   (i_clk),
        .i_load  (div_load),
        .i_shift (div_shift),
        .i_raw   (i_in_data.left_outer[SENSOR_BITS-1:0]),
        .o_quot  (q_lo)
    );

    lfsl_div #(.SENSOR_BITS(SENSOR_BITS), .DIVISOR(INNER_DIV)) u_div_ro (
        .i_clk   (i_clk),
        .i_load  (div_load),
        .i_shift (div_shift),
        .i_raw   (i_in_data.right_outer[SENSOR_BITS-1:0]),
        .o_quot  (q_ro)
    );

    lfsl_steer #(.SENSOR_BITS(SENSOR_BITS)) u_steer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (steer_start),
        .i_q_li  (q_li),
        .i_q_ri  (q_ri),
        .i_q_lo  (q_lo),
        .i_q_ro  (q_ro),
        .i_gains (r_gains),
        .i_mult  (slow ? r_slow_speed : r_full_speed),
        .o_done  (steer_done),
        .o_drive (drive)
    );

    lfsl_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_info       (r_info),
        .o_phase_next (phase_next),
        .o_moving     (moving),
        .o_slow       (slow)
    );

    `LFSL_ASSERT_NEXT(a_accept_div, i_in_valid && o_in_ready, r_state == ST_DIV, "accepted transaction did not start division")
    `LFSL_ASSERT_IMPL(a_done_in_calc, steer_done, r_state == ST_CALC, "steering result outside calc state")

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import lfsl_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 45;
    localparam int RAND_PER_SET = 143;
    localparam int N_SETS       = 8;

    localparam longint IN_DIV   = 24000;
    localparam longint LO_DIV   = 20690;
    localparam longint Q16_ONE  = 65536;
    localparam int LINE_TH      = 19200;
    localparam int LINE_TH_LO   = 16552;
    localparam int LIFT_TH      = 21600;
    localparam int LIFT_TH_LO   = 18621;
    localparam int GAP_TH       = 16800;
    localparam int GAP_TH_LO    = 14483;

    typedef enum {K_NOISE, K_TRACK, K_LINE, K_GAP} t_kind;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    t_in_item    in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_item   out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [CFG_ADDR_BITS-1:0] paddr = '0;
    logic [CFG_DATA_BITS-1:0] pwdata = '0;
    logic [CFG_DATA_BITS-1:0] prdata;
    logic        pready;

    t_in_item    pending_items[$];
    t_out_item   expected_cmds[$];
    logic        in_taken = 1'b0;
    int          cyc = 0;
    int          stall_cnt = 0;
    int          fail_count = 0;
    int          n_items = 0;
    int          n_results = 0;
    int          n_gen = 0;
    int          n_laps = 0;
    int          n_presses = 0;
    logic        calm;

    // predictor copy of registers and lap state
    int          slow_q8 = 84;
    int          full_q8 = 256;
    int          inner_q8 = 435;
    int          outer_q8 = 563;
    t_phase      ph = PH_READY;
    logic [1:0]  lines = 2'd0;
    logic [1:0]  target = 2'd0;
    logic        on_line = 1'b0;
    logic        slow_sel = 1'b0;
    logic        btn_released = 1'b1;

    assign calm = (cyc >= 20000 && cyc < 30000);

    line_follow_steer_and_lap_control_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic void motor(longint cmd, int mult, output logic [7:0] mag,
                                  output logic rev);
        longint m;
        if (cmd > 255) cmd = 255;
        if (cmd < -255) cmd = -255;
        m = ((cmd < 0 ? -cmd : cmd) * mult) >> 8;
        rev = (cmd < 0 && m != 0);
        mag = (m > 255) ? 8'd255 : m[7:0];
    endfunction

    function automatic t_out_item predict_motor_step(t_in_item x);
        t_out_item  r;
        longint     n_li, n_ri, n_lo, n_ro, d, dir;
        logic       on08, on09;
        logic [1:0] last_lap;
        int         mult;
        r = '0;
        on08 = x.left_inner > LINE_TH && x.right_inner > LINE_TH &&
               x.left_outer > LINE_TH_LO && x.right_outer > LINE_TH;
        on09 = x.left_inner > LIFT_TH && x.right_inner > LIFT_TH &&
               x.left_outer > LIFT_TH_LO && x.right_outer > LIFT_TH;
        if (ph == PH_POSITION || ph == PH_DRIVE) begin
            n_li = (longint'(x.left_inner) << 16) / IN_DIV;
            n_ri = (longint'(x.right_inner) << 16) / IN_DIV;
            n_lo = (longint'(x.left_outer) << 16) / LO_DIV;
            n_ro = (longint'(x.right_outer) << 16) / IN_DIV;
            if (n_lo > Q16_ONE) n_lo = Q16_ONE;
            d = inner_q8 * (n_li - n_ri) + outer_q8 * (n_lo - n_ro);
            dir = (d * 255) >>> 24;
            last_lap = target - 2'd1;
            if (on08) begin
                on_line = 1'b1;
                if (ph == PH_DRIVE && lines == last_lap) begin
                    ph = PH_READY;
                    n_laps++;
                end
            end else if (on_line && x.left_outer < GAP_TH_LO && x.right_outer < GAP_TH) begin
                lines = lines + 2'd1;
                if (lines == target) begin
                    if (ph == PH_POSITION) begin
                        ph = PH_WAIT;
                    end else begin
                        ph = PH_READY;
                        n_laps++;
                    end
                end
                on_line = 1'b0;
            end
            mult = slow_sel ? slow_q8 : full_q8;
            motor(256 - dir, mult, r.left_pwm, r.left_reverse);
            motor(255 + dir, mult, r.right_pwm, r.right_reverse);
        end else if (ph == PH_WAIT && !x.ir_level) begin
            ph = PH_DRIVE;
            lines = 2'd0;
            slow_sel = 1'b0;
            target = 2'd2;
        end
        if (!x.button_level) begin
            if (btn_released) begin
                btn_released = 1'b0;
                n_presses++;
                case (ph)
                    PH_READY: begin
                        if (!on09) begin
                            ph = PH_POSITION;
                            on_line = 1'b0;
                            slow_sel = 1'b1;
                            target = 2'd1;
                            lines = 2'd0;
                        end
                    end
                    PH_WAIT: begin
                        ph = PH_DRIVE;
                        lines = 2'd0;
                        slow_sel = 1'b0;
                        target = 2'd2;
                    end
                    default: ph = PH_READY;
                endcase
            end
        end else begin
            btn_released = 1'b1;
        end
        r.phase = ph;
        return r;
    endfunction

    function automatic t_in_item mk(int li, int ri, int lo, int ro, bit ir, bit btn);
        t_in_item x;
        x.left_inner   = li[15:0];
        x.right_inner  = ri[15:0];
        x.left_outer   = lo[15:0];
        x.right_outer  = ro[15:0];
        x.ir_level     = ir;
        x.button_level = btn;
        return x;
    endfunction

    function automatic t_in_item gen_item(t_kind k, bit ir, bit btn);
        t_in_item x;
        x = mk($urandom_range(65535, 0), $urandom_range(65535, 0),
               $urandom_range(65535, 0), $urandom_range(65535, 0), ir, btn);
        case (k)
            K_NOISE: begin
                x.ir_level     = 1'($urandom);
                x.button_level = 1'($urandom);
            end
            K_TRACK: begin
                x.left_outer  = 16'($urandom_range(LINE_TH_LO, GAP_TH_LO));
                x.right_outer = 16'($urandom_range(LINE_TH, GAP_TH));
            end
            K_LINE: begin
                x.left_inner  = 16'($urandom_range(65535, LINE_TH + 1));
                x.right_inner = 16'($urandom_range(65535, LINE_TH + 1));
                x.left_outer  = 16'($urandom_range(65535, LINE_TH_LO + 1));
                x.right_outer = 16'($urandom_range(65535, LINE_TH + 1));
            end
            K_GAP: begin
                x.left_outer  = 16'($urandom_range(GAP_TH_LO - 1, 0));
                x.right_outer = 16'($urandom_range(GAP_TH - 1, 0));
            end
        endcase
        return x;
    endfunction

    task automatic push_item(t_in_item x);
        pending_items.push_back(x);
        n_gen++;
    endtask

    // occasional noise breaks up otherwise clean lap sequences
    task automatic lap_step(t_kind k, bit ir, bit btn);
        if ($urandom_range(99) < 4) push_item(gen_item(K_NOISE, 1'b1, 1'b1));
        push_item(gen_item(k, ir, btn));
    endtask

    task automatic lap_segment();
        repeat ($urandom_range(4, 0)) lap_step(K_TRACK, 1'b1, 1'b1);
        repeat ($urandom_range(3, 1)) lap_step(K_LINE, 1'b1, 1'b1);
        repeat ($urandom_range(3, 1)) lap_step(K_GAP, 1'b1, 1'b1);
    endtask

    task automatic push_lap();
        lap_step(K_TRACK, 1'b1, 1'b0);
        lap_step(K_TRACK, 1'b1, 1'b1);
        lap_segment();
        repeat ($urandom_range(3, 0)) lap_step(K_TRACK, 1'b1, 1'b1);
        if ($urandom_range(1)) begin
            lap_step(K_TRACK, 1'b0, 1'b1);
        end else begin
            lap_step(K_TRACK, 1'b1, 1'b0);
            lap_step(K_TRACK, 1'b1, 1'b1);
        end
        lap_segment();
        lap_segment();
    endtask

    task automatic cfg_write(t_reg_idx idx, int unsigned val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_SLOW:  slow_q8  = val & 32'h1FF;
            REG_FULL:  full_q8  = val & 32'h1FF;
            REG_INNER: inner_q8 = val & 32'h3FF;
            REG_OUTER: outer_q8 = val & 32'h3FF;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || in_valid || expected_cmds.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // input driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_taken) begin
            if (pending_items.size() != 0 && (calm || $urandom_range(99) >= 9)) begin
                in_data  <= pending_items.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        out_ready <= calm || ($urandom_range(99) >= 9);
    end

    // monitor, predictor and watchdog counter
    always @(posedge i_clk) begin
        t_out_item want;
        logic      busy;
        cyc <= cyc + 1;
        busy = psel;
        if (!i_rst_n) begin
            in_taken  <= 1'b0;
            stall_cnt <= 0;
        end else begin
            if (out_valid && out_ready) begin
                busy = 1'b1;
                n_results++;
                if (expected_cmds.size() == 0) begin
                    $error("result transaction with nothing expected");
                    fail_count++;
                end else begin
                    want = expected_cmds.pop_front();
                    if (out_data.left_pwm !== want.left_pwm) begin
                        $error("left_pwm expected %0d got %0d", want.left_pwm, out_data.left_pwm);
                        fail_count++;
                    end
                    if (out_data.right_pwm !== want.right_pwm) begin
                        $error("right_pwm expected %0d got %0d", want.right_pwm,
                               out_data.right_pwm);
                        fail_count++;
                    end
                    if (out_data.left_reverse !== want.left_reverse) begin
                        $error("left_reverse expected %0d got %0d", want.left_reverse,
                               out_data.left_reverse);
                        fail_count++;
                    end
                    if (out_data.right_reverse !== want.right_reverse) begin
                        $error("right_reverse expected %0d got %0d", want.right_reverse,
                               out_data.right_reverse);
                        fail_count++;
                    end
                    if (out_data.phase !== want.phase) begin
                        $error("phase expected %0d got %0d", want.phase, out_data.phase);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready) begin
                busy = 1'b1;
                n_items++;
                expected_cmds.push_back(predict_motor_step(in_data));
                in_taken <= 1'b1;
            end else begin
                in_taken <= 1'b0;
            end
            stall_cnt <= busy ? 0 : stall_cnt + 1;
        end
    end

    always @(posedge i_clk) begin
        if (stall_cnt == STALL_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int          s;
        int unsigned v_slow, v_full, v_inner, v_outer;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: button lift, thresholds, full lap, button walk through phases
        push_item(mk(0, 0, 0, 0, 1, 1));
        push_item(mk(65535, 65535, 65535, 65535, 1, 0));
        push_item(mk(65535, 65535, 65535, 65535, 0, 1));
        push_item(mk(0, 0, 0, 0, 1, 0));
        push_item(mk(65535, 0, 0, 65535, 1, 1));
        push_item(mk(0, 65535, 65535, 0, 1, 1));
        push_item(mk(19200, 19200, 16552, 19200, 1, 1));
        push_item(mk(19201, 19201, 16553, 19201, 1, 1));
        push_item(mk(30000, 30000, 14483, 16800, 1, 1));
        push_item(mk(30000, 30000, 14482, 16799, 1, 1));
        push_item(mk(1000, 2000, 3000, 4000, 0, 1));
        push_item(mk(24000, 12000, 65535, 6000, 1, 1));
        push_item(mk(40000, 40000, 40000, 40000, 1, 1));
        push_item(mk(100, 100, 100, 100, 1, 1));
        push_item(mk(60000, 60000, 60000, 60000, 1, 1));
        push_item(mk(5000, 5000, 5000, 5000, 1, 0));
        push_item(mk(5000, 5000, 5000, 5000, 1, 1));
        push_item(mk(5000, 5000, 5000, 5000, 1, 0));
        push_item(mk(5000, 5000, 5000, 5000, 1, 1));
        push_item(mk(5000, 5000, 5000, 5000, 1, 0));
        push_item(mk(50000, 50000, 50000, 50000, 1, 1));
        push_item(mk(10, 10, 10, 10, 1, 1));
        push_item(mk(10, 10, 10, 10, 1, 0));
        push_item(mk(10, 10, 10, 10, 1, 1));
        push_item(mk(10, 10, 10, 10, 1, 0));
        push_item(mk(10, 10, 10, 10, 1, 1));
        wait_drained();

        for (s = 0; s < N_SETS; s++) begin
            case (s)
                0: begin
                    v_slow = 511; v_full = 511; v_inner = 1023; v_outer = 1023;
                end
                1: begin
                    v_slow = 0; v_full = 0; v_inner = 0; v_outer = 0;
                end
                2: begin
                    v_slow = 256; v_full = 256; v_inner = 435; v_outer = 563;
                end
                default: begin
                    v_slow  = $urandom_range(511, 0);
                    v_full  = $urandom_range(511, 0);
                    v_inner = $urandom_range(1023, 0);
                    v_outer = $urandom_range(1023, 0);
                end
            endcase
            cfg_write(REG_SLOW, v_slow);
            cfg_write(REG_FULL, v_full);
            cfg_write(REG_INNER, v_inner);
            cfg_write(REG_OUTER, v_outer);
            n_gen = 0;
            while (n_gen < RAND_PER_SET) begin
                if ($urandom_range(99) < 85) begin
                    push_lap();
                end else begin
                    repeat ($urandom_range(5, 1)) push_item(gen_item(K_NOISE, 1'b1, 1'b1));
                end
            end
            wait_drained();
        end

        $display("Ran %0d input transactions over %0d register settings plus reset defaults.",
                 n_items, N_SETS);
        $display("Compared %0d results; %0d laps finished at a stop line, %0d button edges.",
                 n_results, n_laps, n_presses);
        if (fail_count == 0 && expected_cmds.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/lfsl_pkg.sv
hdl/lfsl_div.sv
hdl/lfsl_steer.sv
hdl/lfsl_ctrl.sv
hdl/line_follow_steer_and_lap_control_core.sv
tb/tb.sv
